// ----- sv/phlm_pkg.sv -----
// Shared types, constants and codes for the peak-hold level meter.
package phlm_pkg;

   localparam int CH_W          = 4;
   localparam int PEAK_W        = 24;
   localparam int DB_W          = 15;
   localparam int CSR_IDX_W     = 2;
   localparam int LEVEL_W       = 4;
   localparam int SYM_W         = 2;
   localparam int DIVIDEND_W    = 19;
   localparam int QUO_W         = 4;
   localparam int CHANNELS_DEF  = 16;

   localparam int REQ_TDATA_W   = 24;
   localparam int REQ_TUSER_W   = 5;
   localparam int RSP_TDATA_W   = 16;
   localparam int RSP_TUSER_W   = 5;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FLOOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_FLOOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP   = 2'd2;

   localparam logic [DB_W-1:0] SCALE_FLOOR_RST  = 15'd16384;
   localparam logic [DB_W-1:0] SIGNAL_FLOOR_RST = 15'd17920;
   localparam logic [DB_W-1:0] DECAY_STEP_RST   = 15'd256;

   localparam logic signed [PEAK_W-1:0] PEAK_MIN     = 24'sh800000;
   localparam logic signed [PEAK_W-1:0] DISPLAY_GATE = -24'sd15360;

   localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 4'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 4'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_CLIP  = 4'd13;
   localparam logic [LEVEL_W-1:0] LED_MAX     = 4'd12;
   localparam logic [LEVEL_W-1:0] SHOW_COLON2 = 4'd10;
   localparam logic [LEVEL_W-1:0] SHOW_DOT    = 4'd7;
   localparam logic [LEVEL_W-1:0] SHOW_COLON1 = 4'd4;
   localparam logic [LEVEL_W-1:0] SHOW_LOW    = 4'd1;

   // display characters
   localparam logic [SYM_W-1:0] SYM_SPACE = 2'd0;
   localparam logic [SYM_W-1:0] SYM_DOT   = 2'd1;
   localparam logic [SYM_W-1:0] SYM_COLON = 2'd2;
   localparam logic [SYM_W-1:0] SYM_STAR  = 2'd3;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DB_W-1:0]       divisor;
   } div_req_type;

endpackage

// ----- sv/phlm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module phlm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/phlm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, 4-bit quotient.
module phlm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  phlm_pkg::div_req_type      req,
   output logic                       done,
   output logic [phlm_pkg::QUO_W-1:0] quotient
);
   import phlm_pkg::*;

   localparam int DVS_W = DB_W + QUO_W - 1;
   localparam int CNT_W = $clog2(QUO_W);

   logic [DIVIDEND_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [QUO_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] dvs_ext;
   logic                  fits;

   assign dvs_ext = DIVIDEND_W'(dvs_ff);
   assign fits    = rem_ff >= dvs_ext;

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.dividend;
         dvs_in  = {req.divisor, (QUO_W-1)'(0)};
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one trial subtract per cycle, divisor walks down one bit
         if (fits) begin
            rem_in = rem_ff - dvs_ext;
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/peak_hold_level_meter.sv -----
// Top level of the per-channel peak-hold level meter.
//
// Usage:
//  - req channel: one transfer per meter update. tuser carries the channel
//    index and the active flag, tdata the new peak in dB (signed, 8 fraction
//    bits). The block takes one item at a time; req_tready is high only while
//    the sequencer is idle and out of reset.
//  - rsp channel: exactly one transfer per request, in request order, with the
//    LED segment count, the two display characters and the clip flag.
//  - csr channel: register writes (scale floor, signal floor, decay step),
//    ready whenever out of reset. Write only while no request is in flight.
//  - Path: an active channel passes the read, decay, merge and quantize states
//    and, when the level is not decided by a threshold, the linear segment's
//    4-step divider before the result; an inactive channel goes straight to
//    the result. The divider and the held-peak RAM read/write pass set the path.
//  - Between requests, with rsp not stalled: the sequencer returns to idle
//    on the edge the result is registered and accepts on the next one.
//  - The result sits in an output register, so a new request is taken while
//    the last result waits; a further result waits in the sequencer until the
//    receiver drains rsp.
//  - Reset: registers return to their defaults and every channel's held peak
//    reads as silence (per-channel valid bits), with no clearing pass.
module peak_hold_level_meter #(
   parameter int CHANNELS = phlm_pkg::CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req: tdata = peak_db[23:0]; tuser = channel[3:0], active[4]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [phlm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [phlm_pkg::REQ_TUSER_W-1:0] req_tuser,
   // rsp: tdata = led_level[3:0], top_symbol[5:4], bottom_symbol[7:6],
   //      clip[8], zero[15:9]; tuser = channel_out[3:0], led_valid[4]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [phlm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [phlm_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // csr write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [phlm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [phlm_pkg::DB_W-1:0]        csr_data
);
   import phlm_pkg::*;

   localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EW   = (AW > CH_W) ? AW : CH_W;
   localparam int WIDE = PEAK_W + 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_DECAY = 7'b0000100,
      ST_MERGE = 7'b0001000,
      ST_QUANT = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [DB_W-1:0] scale_ff, scale_in;
   logic [DB_W-1:0] sig_ff, sig_in;
   logic [DB_W-1:0] decay_ff, decay_in;

   logic [CH_W-1:0]          ch_ff, ch_in;
   logic                     active_ff, active_in;
   logic                     inrange_ff, inrange_in;
   logic signed [PEAK_W-1:0] peak_ff, peak_in;
   logic signed [PEAK_W-1:0] hold_ff, hold_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [CHANNELS-1:0]      seen_ff, seen_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0]   rsp_user_ff, rsp_user_in;

   logic [EW-1:0]            ch_ext;
   logic [AW-1:0]            addr;
   logic                     ram_wr;
   logic [PEAK_W-1:0]        ram_rd;
   logic signed [PEAK_W-1:0] stored;
   logic signed [WIDE-1:0]   hold_w, neg_2scale, neg_sig, neg_scale, decayed;
   logic [WIDE-1:0]          numer_w;
   logic [DB_W-1:0]          numer;
   div_req_type              div_req;
   logic                     div_done;
   logic [QUO_W-1:0]         div_quo;
   logic                     out_free;
   logic                     clip;
   logic [LEVEL_W-1:0]       led, shown;
   logic [SYM_W-1:0]         top_sym, bot_sym;

   assign ch_ext     = EW'(ch_ff);
   assign addr       = ch_ext[AW-1:0];
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign csr_ready  = !reset;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // held peak per channel
   phlm_ram #(
      .WIDTH (PEAK_W),
      .DEPTH (CHANNELS)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr),
      .wr_data (hold_in),
      .rd_addr (addr),
      .rd_data (ram_rd)
   );

   phlm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // never-written channel reads as silence
   assign stored     = seen_ff[addr] ? $signed(ram_rd) : PEAK_MIN;
   assign hold_w     = WIDE'(hold_ff);
   assign neg_2scale = -$signed({(WIDE-DB_W-1)'(0), scale_ff, 1'b0});
   assign neg_scale  = -$signed({(WIDE-DB_W)'(0), scale_ff});
   assign neg_sig    = -$signed({(WIDE-DB_W)'(0), sig_ff});
   assign decayed    = WIDE'(stored) - $signed({(WIDE-DB_W-1)'(0), decay_ff, 1'b0});
   assign numer_w    = unsigned'(hold_w) + WIDE'(scale_ff);
   assign numer      = numer_w[DB_W-1:0];

   // result formatting
   assign clip  = !hold_ff[PEAK_W-1];
   assign led   = (level_ff > LED_MAX) ? LED_MAX : level_ff;
   assign shown = (hold_ff > DISPLAY_GATE) ? level_ff : LEVEL_NONE;

   always_comb begin
      top_sym = SYM_SPACE;
      bot_sym = SYM_SPACE;
      priority if (shown >= SHOW_COLON2) begin
         top_sym = SYM_COLON;
         bot_sym = SYM_COLON;
      end else if (shown >= SHOW_DOT) begin
         top_sym = SYM_DOT;
         bot_sym = SYM_COLON;
      end else if (shown >= SHOW_COLON1) begin
         bot_sym = SYM_COLON;
      end else if (shown >= SHOW_LOW) begin
         bot_sym = SYM_DOT;
      end else begin
         bot_sym = SYM_SPACE;
      end
      if (clip) begin
         top_sym = SYM_STAR;
      end
   end

   // csr writes
   always_comb begin
      scale_in = scale_ff;
      sig_in   = sig_ff;
      decay_in = decay_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE_FLOOR:  scale_in = csr_data;
            CSR_SIGNAL_FLOOR: sig_in   = csr_data;
            CSR_DECAY_STEP:   decay_in = csr_data;
            default:          ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      active_in    = active_ff;
      inrange_in   = inrange_ff;
      peak_in      = peak_ff;
      hold_in      = hold_ff;
      level_in     = level_ff;
      seen_in      = seen_ff;
      ram_wr       = 1'b0;
      div_req      = '{start: 1'b0, dividend: '0, divisor: scale_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ch_in      = req_tuser[CH_W-1:0];
               active_in  = req_tuser[CH_W];
               peak_in    = $signed(req_tdata[PEAK_W-1:0]);
               inrange_in = int'(req_tuser[CH_W-1:0]) < CHANNELS;
               state_in   = req_tuser[CH_W] ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            // RAM read address is up this cycle
            state_in = ST_DECAY;
         end
         ST_DECAY: begin
            hold_in = stored;
            if (WIDE'(stored) > neg_2scale) begin
               hold_in = decayed[PEAK_W-1:0];
            end
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!inrange_ff || peak_ff > hold_ff) begin
               hold_in = peak_ff;
            end
            if (inrange_ff) begin
               ram_wr        = 1'b1;
               seen_in[addr] = 1'b1;
            end
            state_in = ST_QUANT;
         end
         ST_QUANT: begin
            state_in = ST_DONE;
            priority if (!hold_ff[PEAK_W-1]) begin
               level_in = LEVEL_CLIP;
            end else if (hold_w <= neg_sig) begin
               level_in = LEVEL_NONE;
            end else if (hold_w <= neg_scale || scale_ff == '0) begin
               level_in = LEVEL_FLOOR;
            end else begin
               // (p + scale) * 11 / scale, times 11 as shift-add
               div_req.start    = 1'b1;
               div_req.dividend = (DIVIDEND_W'(numer) << 3) + (DIVIDEND_W'(numer) << 1)
                                  + DIVIDEND_W'(numer);
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               level_in = div_quo + 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = {active_ff, ch_ff};
               if (active_ff) begin
                  rsp_data_in = RSP_TDATA_W'({clip, bot_sym, top_sym, led});
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= SCALE_FLOOR_RST;
         sig_ff       <= SIGNAL_FLOOR_RST;
         decay_ff     <= DECAY_STEP_RST;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         sig_ff       <= sig_in;
         decay_ff     <= decay_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      active_ff   <= active_in;
      inrange_ff  <= inrange_in;
      peak_ff     <= peak_in;
      hold_ff     <= hold_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the peak-hold level meter: directed and random updates.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import phlm_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 8;
   // longest path through the block is the divider case
   localparam int SETTLE_CYCLES  = 16;
   localparam int LINEAR_SPAN    = 11;
   localparam int NUM_SETTINGS   = 6;
   localparam int UPDATES_PER_SETTING = 230;

   typedef struct packed {
      logic [CH_W-1:0]          channel;
      logic                     active;
      logic signed [PEAK_W-1:0] peak;
   } meter_update_type;

   typedef struct packed {
      logic [CH_W-1:0]    channel;
      logic               led_valid;
      logic [LEVEL_W-1:0] led_level;
      logic [SYM_W-1:0]   top_symbol;
      logic [SYM_W-1:0]   bottom_symbol;
      logic               clip;
   } meter_reading_type;

   // DUT-facing signals; every input starts at a known value
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // peak_db
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // channel, active
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // led_level, top, bottom, clip, zero pad
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // channel_out, led_valid
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [DB_W-1:0]        csr_data = '0;

   // handshake flags sampled at the rising edge, read by the falling-edge drivers
   logic req_took = 1'b0;
   logic csr_took = 1'b0;

   // idle percentages for the current phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   meter_update_type  pending_updates[$];
   meter_reading_type predicted_readings[$];

   // shadow of the meter state and registers
   int held_peak [CHANNELS_DEF];
   int scale_floor_cfg  = int'(SCALE_FLOOR_RST);
   int signal_floor_cfg = int'(SIGNAL_FLOOR_RST);
   int decay_step_cfg   = int'(DECAY_STEP_RST);

   int errors = 0;
   int updates_taken = 0;
   int readings_checked = 0;
   int inactive_seen = 0;
   int clips_seen = 0;

   // floor settings: {scale_floor, signal_floor, decay_step}
   int cfg_table [NUM_SETTINGS][3] = '{
      '{256,   32512, 0},
      '{32512, 256,   32767},
      '{0,     3000,  100},      // zero scale floor: every negative peak hits a threshold
      '{32767, 32767, 1},
      '{5000,  9000,  700},
      '{16384, 17920, 256}
   };

   peak_hold_level_meter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // generous fixed limit, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("%0t ns: timeout, %0d readings still outstanding", $time,
               predicted_readings.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Held peak to 0..13 level. Signal floor is tested before scale floor.
   function automatic int quantize_peak(int p);
      if (p >= 0)
         return LEVEL_CLIP;
      if (p <= -signal_floor_cfg)
         return LEVEL_NONE;
      if (p <= -scale_floor_cfg || scale_floor_cfg == 0)
         return LEVEL_FLOOR;
      return ((p + scale_floor_cfg) * LINEAR_SPAN) / scale_floor_cfg + 1;
   endfunction

   // Applies one update to the shadow state and returns the reading it yields.
   function automatic meter_reading_type predict_reading(meter_update_type upd);
      meter_reading_type r;
      int p;
      int h;
      int lvl;
      int shown;
      r = '0;
      r.channel = upd.channel;
      if (!upd.active)
         return r;   // state untouched, everything blank
      p = int'($signed(upd.peak));
      if (int'(upd.channel) < CHANNELS_DEF) begin
         h = held_peak[upd.channel];
         // ballistics: fall only while above twice the scale depth
         if (h > -2 * scale_floor_cfg)
            h -= 2 * decay_step_cfg;
         if (p > h)
            h = p;
         else
            p = h;
         held_peak[upd.channel] = h;
      end
      lvl = quantize_peak(p);
      r.led_valid = 1'b1;
      r.clip      = (p >= 0);
      r.led_level = (lvl > LED_MAX) ? LED_MAX : LEVEL_W'(lvl);
      // display is blank at or below -60 dB
      shown = (p > DISPLAY_GATE) ? lvl : 0;
      r.top_symbol    = SYM_SPACE;
      r.bottom_symbol = SYM_SPACE;
      if (shown >= SHOW_COLON2) begin
         r.top_symbol    = SYM_COLON;
         r.bottom_symbol = SYM_COLON;
      end else if (shown >= SHOW_DOT) begin
         r.top_symbol    = SYM_DOT;
         r.bottom_symbol = SYM_COLON;
      end else if (shown >= SHOW_COLON1) begin
         r.bottom_symbol = SYM_COLON;
      end else if (shown >= SHOW_LOW) begin
         r.bottom_symbol = SYM_DOT;
      end
      if (r.clip)
         r.top_symbol = SYM_STAR;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_update(input int ch, input bit act, input int peak);
      meter_update_type u;
      u.channel = CH_W'(ch);
      u.active  = act;
      u.peak    = PEAK_W'(peak);
      pending_updates.push_back(u);
   endtask

   // Random update biased toward the thresholds of the current setting.
   function automatic meter_update_type random_update();
      meter_update_type u;
      int k;
      int pick;
      int peak;
      int span;
      k = $urandom_range(0, 99);
      u.channel = CH_W'($urandom_range(0, 15));
      u.active  = 1'b1;
      span = scale_floor_cfg + signal_floor_cfg + 2000;
      if (k < 12) begin
         u.active = 1'b0;                  // inactive, any peak
         peak = int'($urandom());
      end else if (k < 22) begin
         peak = int'($urandom());          // full 24-bit range
      end else if (k < 35) begin
         peak = int'(PEAK_MIN);            // silence, lets the hold decay
      end else if (k < 55) begin
         pick = $urandom_range(0, 13);
         case (pick)
            0:  peak = 0;
            1:  peak = -1;
            2:  peak = 1;
            3:  peak = -signal_floor_cfg;
            4:  peak = -signal_floor_cfg + 1;
            5:  peak = -signal_floor_cfg - 1;
            6:  peak = -scale_floor_cfg;
            7:  peak = -scale_floor_cfg + 1;
            8:  peak = -scale_floor_cfg - 1;
            9:  peak = int'(DISPLAY_GATE);
            10: peak = int'(DISPLAY_GATE) + 1;
            11: peak = -2 * scale_floor_cfg;
            12: peak = -2 * scale_floor_cfg + 1;
            default: peak = 8388607;
         endcase
      end else begin
         peak = int'($urandom_range(0, 1500)) - int'($urandom_range(0, span));
      end
      u.peak = PEAK_W'(peak);
      return u;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= DB_W'(value);
      @(negedge clock);
      while (!csr_took)
         @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender holds off until everything queued has come back.
   task automatic wait_drained();
      while (pending_updates.size() != 0 || req_tvalid || predicted_readings.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: new values at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive
      meter_update_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         // previous transfer done (or none pending): maybe present the next one
         if (pending_updates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = pending_updates.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.peak;
            req_tuser  <= {nxt.active, nxt.channel};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor and scoreboard: everything sampled at the rising edge
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input int ch, input int want,
                                       input int got);
      if (want != got) begin
         errors++;
         $display("%0t ns: ch %0d %s mismatch, expected %0d actual %0d", $time, ch, name,
                  want, got);
      end
   endfunction

   always @(posedge clock) begin : observe
      meter_reading_type got;
      meter_reading_type want;
      req_took <= req_tvalid && req_tready && !reset;
      csr_took <= csr_valid && csr_ready && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCALE_FLOOR:  scale_floor_cfg  = int'(csr_data);
               CSR_SIGNAL_FLOOR: signal_floor_cfg = int'(csr_data);
               CSR_DECAY_STEP:   decay_step_cfg   = int'(csr_data);
               default: ;
            endcase
         end
         // result side first, so a stray transfer cannot hide behind a fresh prediction
         if (rsp_tvalid && rsp_tready) begin
            got.channel       = rsp_tuser[3:0];
            got.led_valid     = rsp_tuser[4];
            got.led_level     = rsp_tdata[3:0];
            got.top_symbol    = rsp_tdata[5:4];
            got.bottom_symbol = rsp_tdata[7:6];
            got.clip          = rsp_tdata[8];
            if (predicted_readings.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected reading, expected none actual ch %0d tdata %h",
                        $time, got.channel, rsp_tdata);
            end else begin
               want = predicted_readings.pop_front();
               readings_checked++;
               check_field("channel_out", want.channel, want.channel, got.channel);
               check_field("led_valid", want.channel, want.led_valid, got.led_valid);
               check_field("led_level", want.channel, want.led_level, got.led_level);
               check_field("top_symbol", want.channel, want.top_symbol, got.top_symbol);
               check_field("bottom_symbol", want.channel, want.bottom_symbol,
                           got.bottom_symbol);
               check_field("clip", want.channel, want.clip, got.clip);
               check_field("tdata pad", want.channel, 0, int'(rsp_tdata[15:9]));
            end
         end
         if (req_tvalid && req_tready) begin
            updates_taken++;
            want = predict_reading({req_tuser[3:0], req_tuser[4], req_tdata});
            if (!req_tuser[4])
               inactive_seen++;
            if (want.clip)
               clips_seen++;
            predicted_readings.push_back(want);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : sequence_main
      int s;
      int n;
      for (int c = 0; c < CHANNELS_DEF; c++)
         held_peak[c] = int'(PEAK_MIN);
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass, reset register values
      send_idle_pct = 19;
      recv_idle_pct = 58;
      add_update(0, 1'b1, 0);                 // exactly 0 dB: clip, star
      add_update(0, 1'b1, 8388607);           // top of input range
      add_update(1, 1'b1, int'(PEAK_MIN));    // silence on a fresh channel
      add_update(2, 1'b0, 0);                 // inactive: blank, state kept
      add_update(2, 1'b1, -17920);            // on the signal floor
      add_update(3, 1'b1, -17919);            // just above it
      add_update(3, 1'b1, -16384);            // on the scale floor
      add_update(4, 1'b1, -16383);            // bottom of the linear segment
      add_update(5, 1'b1, -15360);            // on the -60 dB display gate
      add_update(5, 1'b1, -15359);            // just above the gate
      add_update(6, 1'b1, -1);                // top of the linear segment
      add_update(7, 1'b1, -5000);
      add_update(8, 1'b1, -32767);            // just above twice the scale depth
      add_update(8, 1'b1, int'(PEAK_MIN));    // decays once, crosses below
      add_update(8, 1'b1, int'(PEAK_MIN));    // no further decay
      add_update(9, 1'b0, int'(PEAK_MIN));
      add_update(10, 1'b1, -8000);
      add_update(10, 1'b1, int'(PEAK_MIN));   // hold falls by twice the step
      add_update(15, 1'b1, -200);             // master meters
      add_update(14, 1'b1, -300);
      add_update(13, 1'b1, 256);
      add_update(12, 1'b1, -10000);
      add_update(9, 1'b1, -4194304);
      add_update(0, 1'b0, 0);                 // inactive over a held clip
      add_update(0, 1'b1, int'(PEAK_MIN));    // hold still near the top

      // random passes, one per register setting, idle pattern rotating
      for (s = 0; s < NUM_SETTINGS; s++) begin
         // registers only change with the block fully drained
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_csr(CSR_SCALE_FLOOR, cfg_table[s][0]);
         write_csr(CSR_SIGNAL_FLOOR, cfg_table[s][1]);
         write_csr(CSR_DECAY_STEP, cfg_table[s][2]);
         case (s % 3)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (n = 0; n < UPDATES_PER_SETTING; n++)
            pending_updates.push_back(random_update());
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_readings.size() != 0) begin
         errors += predicted_readings.size();
         $display("%0t ns: %0d readings never arrived", $time, predicted_readings.size());
      end

      $display("Meter run: %0d updates (%0d inactive, %0d clipping), %0d readings checked",
               updates_taken, inactive_seen, clips_seen, readings_checked);
      $display("Register settings: reset values plus %0d sets incl. zero and full floors",
               NUM_SETTINGS);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- peak_hold_level_meter.f -----
sv/phlm_pkg.sv
sv/phlm_ram.sv
sv/phlm_div.sv
sv/peak_hold_level_meter.sv
verif/testbench.sv
